/* rtl/lkvc_pkg.sv */
package lkvc_pkg;

  localparam int unsigned Entries = 16;
  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned RankW = $clog2(Entries);
  localparam int unsigned CapW = 5;
  localparam int unsigned KeyW = 32;
  localparam int unsigned ValW = 32;
  localparam logic [CapW-1:0] CapReset = CapW'(16);

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef struct packed {
    logic clear;
    logic start;
    logic scan_step;
    logic fill_step;
    logic age_step;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic fill_last;
    logic age_last;
  } status_t;

endpackage

/* rtl/lkvc_in_if.sv */
interface lkvc_in_if;
  logic valid;
  logic ready;
  logic opcode;
  logic signed [lkvc_pkg::KeyW-1:0] key;
  logic signed [lkvc_pkg::ValW-1:0] data_in;

  modport source (output valid, opcode, key, data_in, input ready);
  modport sink (input valid, opcode, key, data_in, output ready);
endinterface

/* rtl/lkvc_out_if.sv */
interface lkvc_out_if;
  logic valid;
  logic ready;
  logic found;
  logic signed [lkvc_pkg::ValW-1:0] data_out;

  modport source (output valid, found, data_out, input ready);
  modport sink (input valid, found, data_out, output ready);
endinterface

/* rtl/lkvc_datapath.sv */
module lkvc_datapath (
  input  logic clk,
  input  logic rst,
  input  lkvc_pkg::cmd_t cmd,
  output lkvc_pkg::status_t status,
  input  logic [lkvc_pkg::CapW-1:0] cap_wdata,
  input  logic in_opcode,
  input  logic [lkvc_pkg::KeyW-1:0] in_key,
  input  logic [lkvc_pkg::ValW-1:0] in_data,
  output logic res_found,
  output logic [lkvc_pkg::ValW-1:0] res_data
);

  localparam int unsigned IdxW = lkvc_pkg::IdxW;
  localparam int unsigned RankW = lkvc_pkg::RankW;

  logic [lkvc_pkg::KeyW-1:0] keys [lkvc_pkg::Entries];
  logic [lkvc_pkg::ValW-1:0] vals [lkvc_pkg::Entries];
  logic [lkvc_pkg::Entries-1:0] valid;
  logic [RankW-1:0] rank [lkvc_pkg::Entries];
  logic [IdxW:0] occupancy;
  logic [lkvc_pkg::CapW-1:0] capacity;

  logic op;
  logic [lkvc_pkg::KeyW-1:0] key;
  logic [lkvc_pkg::ValW-1:0] data;
  logic [IdxW-1:0] ptr;
  logic hit;
  logic [IdxW-1:0] hit_idx;
  logic free_seen;
  logic [IdxW-1:0] free_idx;
  logic old_seen;
  logic [IdxW-1:0] old_idx;
  logic do_promote;
  logic [IdxW-1:0] slot;
  logic [RankW:0] limit;

  logic [IdxW:0] cap_eff;
  logic [lkvc_pkg::KeyW-1:0] rd_key;
  logic [RankW-1:0] rd_rank;
  logic rd_valid;

  assign cap_eff = (capacity > lkvc_pkg::CapW'(lkvc_pkg::Entries)) ?
                   (IdxW+1)'(lkvc_pkg::Entries) : (IdxW+1)'(capacity);
  assign rd_key = keys[ptr];
  assign rd_rank = rank[ptr];
  assign rd_valid = valid[ptr];

  assign status.scan_last = (ptr == IdxW'(lkvc_pkg::Entries - 1));
  assign status.fill_last = 1'b1;
  assign status.age_last = (ptr == IdxW'(lkvc_pkg::Entries - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkvc_pkg::CapReset;
      valid <= '0;
      occupancy <= '0;
      for (int i = 0; i < lkvc_pkg::Entries; i++) begin
        rank[i] <= '0;
      end
    end else if (cmd.clear) begin
      capacity <= cap_wdata;
      valid <= '0;
      occupancy <= '0;
    end else begin
      if (cmd.start) begin
        op <= in_opcode;
        key <= in_key;
        data <= in_data;
        ptr <= '0;
        hit <= 1'b0;
        free_seen <= 1'b0;
        old_seen <= 1'b0;
        do_promote <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (rd_valid && rd_key == key && !hit) begin
          hit <= 1'b1;
          hit_idx <= ptr;
        end
        if (!rd_valid && !free_seen) begin
          free_seen <= 1'b1;
          free_idx <= ptr;
        end
        if (rd_valid && !old_seen && occupancy != '0 &&
            (IdxW+1)'(rd_rank) == occupancy - 1'b1) begin
          old_seen <= 1'b1;
          old_idx <= ptr;
        end
        ptr <= ptr + 1'b1;
      end
      if (cmd.fill_step) begin
        ptr <= '0;
        if (hit) begin
          res_found <= 1'b1;
          res_data <= (op == lkvc_pkg::OP_GET) ? vals[hit_idx] : '0;
          if (op == lkvc_pkg::OP_PUT) begin
            vals[hit_idx] <= data;
          end
          do_promote <= 1'b1;
          slot <= hit_idx;
          limit <= (RankW+1)'(rank[hit_idx]);
        end else begin
          res_found <= 1'b0;
          res_data <= (op == lkvc_pkg::OP_GET) ? '1 : '0;
          if (op == lkvc_pkg::OP_PUT && cap_eff != '0) begin
            if (occupancy < cap_eff) begin
              if (free_seen) begin
                keys[free_idx] <= key;
                vals[free_idx] <= data;
                valid[free_idx] <= 1'b1;
                occupancy <= occupancy + 1'b1;
                do_promote <= 1'b1;
                slot <= free_idx;
                limit <= (RankW+1)'(occupancy);
              end
            end else if (old_seen) begin
              keys[old_idx] <= key;
              vals[old_idx] <= data;
              do_promote <= 1'b1;
              slot <= old_idx;
              limit <= (RankW+1)'(rank[old_idx]);
            end
          end
        end
      end
      if (cmd.age_step) begin
        if (do_promote) begin
          if (ptr == slot) begin
            rank[ptr] <= '0;
          end else if (rd_valid && (RankW+1)'(rd_rank) < limit) begin
            rank[ptr] <= rd_rank + 1'b1;
          end
        end
        ptr <= ptr + 1'b1;
      end
    end
  end

endmodule

/* rtl/lkvc_ctrl.sv */
module lkvc_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  logic cap_we,
  input  lkvc_pkg::status_t status,
  output lkvc_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_FILL = 5'b00100,
    S_AGE  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.clear = cap_we;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) state_next = S_FILL;
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_last) state_next = S_AGE;
      end
      S_AGE: begin
        cmd.age_step = 1'b1;
        if (status.age_last) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/lru_key_value_cache.sv */
// Fully associative 16-entry key/value store with least-recently-used
// replacement. Each get or put word yields one result word. Once the input
// word is taken, the controller steps through a scan over the entry arrays
// for the key match, a free slot and the oldest entry, an update state, and
// a pass that ages the recency ranks; then the result is valid. The result
// is held until taken and the next word is taken in the cycle after that.
// Writing capacity clears the store and takes effect at once; write it only
// while idle.
module lru_key_value_cache (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [lkvc_pkg::CapW-1:0] cfg_wdata,
  lkvc_in_if.sink  in_ch,
  lkvc_out_if.source out_ch
);

  lkvc_pkg::cmd_t cmd;
  lkvc_pkg::status_t status;
  logic [lkvc_pkg::ValW-1:0] res_data;

  lkvc_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cap_we(cfg_we), .status(status), .cmd(cmd)
  );

  lkvc_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cap_wdata(cfg_wdata),
    .in_opcode(in_ch.opcode), .in_key(in_ch.key), .in_data(in_ch.data_in),
    .res_found(out_ch.found), .res_data(res_data)
  );

  assign out_ch.data_out = res_data;

endmodule

/* rtl/lkvc_checker.sv */
module lkvc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic found,
  input logic [31:0] data_out
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(found))
    else $error("result word changed while stalled");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");

  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> data_out == 32'hFFFF_FFFF || data_out == 32'h0)
    else $error("bad miss value");

endmodule

bind lru_key_value_cache lkvc_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .found(out_ch.found), .data_out(out_ch.data_out)
);
